// ===== hw/rtl/swpb_pkg.sv =====
// Shared constants, status codes and types of the sliding window packet buffer.
package swpb_pkg;

  localparam int DEPTH        = 16;
  localparam int PAYLOAD_BITS = 32;
  localparam int IDX_W        = $clog2(DEPTH);
  localparam int SEQ_W        = 24;
  localparam int WORD_W       = 32;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_REFUSED = 2'd1;
  localparam logic [1:0] ST_REPEAT  = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  typedef struct packed {
    logic [1:0]              status;
    logic [SEQ_W-1:0]        seq;
    logic [PAYLOAD_BITS-1:0] body;
    logic                    now_empty;
  } res_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] raddr;
  } ram_ctl_t;

endpackage

// ===== hw/rtl/swpb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module swpb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/swpb_cmp.sv =====
// Shared subtract-based comparator: equality and greater-or-equal on sequence numbers.
module swpb_cmp
  import swpb_pkg::*;
(
  input  logic [SEQ_W-1:0] a,
  input  logic [SEQ_W:0]   b,
  output logic             eq,
  output logic             ge
);

  logic [SEQ_W+1:0] diff;

  assign diff = {2'b00, a} - {1'b0, b};
  assign ge   = ~diff[SEQ_W+1];
  assign eq   = (diff == '0);

endmodule

// ===== hw/rtl/swpb_ctrl.sv =====
// Sequencer of the buffer: repeat scan, window check, insert and pop over the entry RAMs.
module swpb_ctrl
  import swpb_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_op,
  input  logic [SEQ_W-1:0]        in_seq_num,
  input  logic [PAYLOAD_BITS-1:0] in_body,
  output ram_ctl_t                ram_ctl,
  output logic [SEQ_W-1:0]        wr_seq,
  output logic [PAYLOAD_BITS-1:0] wr_body,
  input  logic [SEQ_W-1:0]        rd_seq,
  input  logic [PAYLOAD_BITS-1:0] rd_body,
  output logic                    res_valid,
  output res_t                    res,
  input  logic                    res_take
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_WIN    = 3'd2;
  localparam logic [2:0] S_POP    = 3'd3;
  localparam logic [2:0] S_RESULT = 3'd4;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  logic [2:0]              state_r, state_nxt;
  logic [IDX_W-1:0]        head_r, head_nxt;
  logic [IDX_W-1:0]        tail_r, tail_nxt;
  logic                    empty_r, empty_nxt;
  logic [DEPTH-1:0]        valid_r, valid_nxt;
  logic [IDX_W-1:0]        cnt_r, cnt_nxt;
  logic [SEQ_W-1:0]        seq_r, seq_nxt;
  logic [PAYLOAD_BITS-1:0] body_r, body_nxt;
  res_t                    res_r, res_nxt;

  logic [IDX_W-1:0] tail_inc;
  logic [IDX_W-1:0] head_inc;
  logic [SEQ_W:0]   cmp_b;
  logic             cmp_eq;
  logic             cmp_ge;

  assign tail_inc = (tail_r == LAST_IDX) ? '0 : tail_r + 1'b1;
  assign head_inc = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;

  assign cmp_b = {1'b0, rd_seq} + ((state_r == S_WIN) ? (SEQ_W+1)'(DEPTH) : '0);

  swpb_cmp u_cmp (
    .a  (seq_r),
    .b  (cmp_b),
    .eq (cmp_eq),
    .ge (cmp_ge)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign res_valid = (state_r == S_RESULT);
  assign res       = res_r;
  assign wr_seq    = (state_r == S_IDLE) ? in_seq_num : seq_r;
  assign wr_body   = (state_r == S_IDLE) ? in_body : body_r;

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    empty_nxt     = empty_r;
    valid_nxt     = valid_r;
    cnt_nxt       = cnt_r;
    seq_nxt       = seq_r;
    body_nxt      = body_r;
    res_nxt       = res_r;
    ram_ctl.we    = 1'b0;
    ram_ctl.waddr = tail_inc;
    ram_ctl.raddr = head_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          seq_nxt            = in_seq_num;
          body_nxt           = in_body;
          res_nxt.status     = ST_OK;
          res_nxt.seq        = '0;
          res_nxt.body       = '0;
          res_nxt.now_empty  = empty_r;
          if (in_op == OP_POP) begin
            if (empty_r) begin
              res_nxt.status = ST_EMPTY;
              state_nxt      = S_RESULT;
            end else begin
              state_nxt = S_POP;
            end
          end else if (empty_r) begin
            ram_ctl.we        = 1'b1;
            ram_ctl.waddr     = '0;
            valid_nxt[0]      = 1'b1;
            head_nxt          = '0;
            tail_nxt          = '0;
            empty_nxt         = 1'b0;
            res_nxt.now_empty = 1'b0;
            state_nxt         = S_RESULT;
          end else if (tail_inc == head_r) begin
            res_nxt.status = ST_REFUSED;
            state_nxt      = S_RESULT;
          end else begin
            ram_ctl.raddr = '0;
            cnt_nxt       = '0;
            state_nxt     = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (valid_r[cnt_r] && cmp_eq) begin
          res_nxt.status = ST_REPEAT;
          state_nxt      = S_RESULT;
        end else if (cnt_r == LAST_IDX) begin
          ram_ctl.raddr = head_r;
          state_nxt     = S_WIN;
        end else begin
          ram_ctl.raddr = cnt_r + 1'b1;
          cnt_nxt       = cnt_r + 1'b1;
        end
      end
      S_WIN: begin
        if (cmp_ge) begin
          res_nxt.status = ST_REFUSED;
        end else begin
          ram_ctl.we         = 1'b1;
          ram_ctl.waddr      = tail_inc;
          valid_nxt[tail_inc] = 1'b1;
          tail_nxt           = tail_inc;
        end
        state_nxt = S_RESULT;
      end
      S_POP: begin
        res_nxt.status      = ST_OK;
        res_nxt.seq         = rd_seq;
        res_nxt.body        = rd_body;
        valid_nxt[head_r]   = 1'b0;
        if (head_r == tail_r) begin
          empty_nxt         = 1'b1;
          head_nxt          = '0;
          tail_nxt          = '0;
          res_nxt.now_empty = 1'b1;
        end else begin
          head_nxt          = head_inc;
          res_nxt.now_empty = 1'b0;
        end
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      empty_r <= 1'b1;
      valid_r <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      empty_r <= empty_nxt;
      valid_r <= valid_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seq_r  <= seq_nxt;
    body_r <= body_nxt;
    res_r  <= res_nxt;
  end

endmodule

// ===== hw/rtl/sliding_window_packet_buffer_core.sv =====
// Top level of the sliding window packet buffer: entry RAMs, sequencer and output register.
// An insert into a non-empty buffer runs a 16-entry repeat scan and a window check on one
// comparator; a repeat ends the scan early, a pop reads the head entry, and a full refusal,
// an insert into an empty buffer or a pop on empty goes straight to the result word. One word
// in flight: the next is accepted the cycle after the result leaves the sequencer.
// Reset: synchronous on rst_n; clears valid marks, head, tail and sets the buffer empty.
module sliding_window_packet_buffer_core
  import swpb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_op,
  input  logic [SEQ_W-1:0]   in_seq_num,
  input  logic [WORD_W-1:0]  in_payload,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [SEQ_W-1:0]   out_seq_num,
  output logic [WORD_W-1:0]  out_payload,
  output logic               out_now_empty
);

  ram_ctl_t                ram_ctl;
  logic [SEQ_W-1:0]        wr_seq;
  logic [PAYLOAD_BITS-1:0] wr_body;
  logic [SEQ_W-1:0]        rd_seq;
  logic [PAYLOAD_BITS-1:0] rd_body;
  logic                    res_valid;
  res_t                    res;
  logic                    res_take;

  logic                    out_valid_r, out_valid_nxt;
  logic [1:0]              status_r;
  logic [SEQ_W-1:0]        oseq_r;
  logic [PAYLOAD_BITS-1:0] obody_r;
  logic                    now_empty_r;

  swpb_ram #(
    .WIDTH (SEQ_W),
    .DEPTH (DEPTH)
  ) u_seq_ram (
    .clk   (clk),
    .we    (ram_ctl.we),
    .waddr (ram_ctl.waddr),
    .wdata (wr_seq),
    .raddr (ram_ctl.raddr),
    .rdata (rd_seq)
  );

  swpb_ram #(
    .WIDTH (PAYLOAD_BITS),
    .DEPTH (DEPTH)
  ) u_body_ram (
    .clk   (clk),
    .we    (ram_ctl.we),
    .waddr (ram_ctl.waddr),
    .wdata (wr_body),
    .raddr (ram_ctl.raddr),
    .rdata (rd_body)
  );

  swpb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_op      (in_op),
    .in_seq_num (in_seq_num),
    .in_body    (in_payload[PAYLOAD_BITS-1:0]),
    .ram_ctl    (ram_ctl),
    .wr_seq     (wr_seq),
    .wr_body    (wr_body),
    .rd_seq     (rd_seq),
    .rd_body    (rd_body),
    .res_valid  (res_valid),
    .res        (res),
    .res_take   (res_take)
  );

  assign res_take = ~out_valid_r | ~out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      status_r    <= res.status;
      oseq_r      <= res.seq;
      obody_r     <= res.body;
      now_empty_r <= res.now_empty;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_seq_num   = oseq_r;
  assign out_payload   = WORD_W'(obody_r);
  assign out_now_empty = now_empty_r;

endmodule

// ===== tb/sliding_window_packet_buffer_core_test.sv =====
// Self-checking testbench for the sliding window packet buffer core.
`timescale 1ns / 100ps

module sliding_window_packet_buffer_core_test;
  import swpb_pkg::*;

  localparam int RANDOM_WORDS = 1525;
  localparam int CALM_WORDS   = 150;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 500000;

  class window_mirror;
    logic [SEQ_W-1:0]        seq_at [DEPTH];
    logic [PAYLOAD_BITS-1:0] body_at [DEPTH];
    bit                      live [DEPTH];
    int unsigned             head;
    int unsigned             tail;
    bit                      drained;
    res_t                    pending_answers[$];
    int unsigned             errors;
    int unsigned             checked;
    int unsigned             status_count [4];

    function new();
      foreach (live[i]) begin
        live[i] = 1'b0;
        seq_at[i] = '0;
        body_at[i] = '0;
      end
      head = 0;
      tail = 0;
      drained = 1'b1;
      errors = 0;
      checked = 0;
      foreach (status_count[i]) status_count[i] = 0;
    endfunction

    function bit holds(logic [SEQ_W-1:0] seq);
      foreach (live[i]) begin
        if (live[i] && seq_at[i] == seq) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void store(int unsigned slot, logic [SEQ_W-1:0] seq, logic [WORD_W-1:0] body);
      seq_at[slot] = seq;
      body_at[slot] = body[PAYLOAD_BITS-1:0];
      live[slot] = 1'b1;
    endfunction

    function bit none_held();
      return drained;
    endfunction

    function logic [SEQ_W-1:0] oldest_seq();
      return seq_at[head];
    endfunction

    function int unsigned outstanding();
      return pending_answers.size();
    endfunction

    function void note_request(logic op, logic [SEQ_W-1:0] seq, logic [WORD_W-1:0] body);
      res_t        r;
      int unsigned nxt;
      r = '0;
      if (op == OP_INSERT) begin
        if (drained) begin
          head = 0;
          tail = 0;
          store(0, seq, body);
          drained = 1'b0;
          r.status = ST_OK;
        end else begin
          nxt = (tail + 1) % DEPTH;
          if (nxt == head) begin
            r.status = ST_REFUSED;
          end else if (holds(seq)) begin
            r.status = ST_REPEAT;
          end else if (32'(seq) >= 32'(seq_at[head]) + DEPTH) begin
            r.status = ST_REFUSED;
          end else begin
            tail = nxt;
            store(nxt, seq, body);
            r.status = ST_OK;
          end
        end
      end else if (drained) begin
        r.status = ST_EMPTY;
      end else begin
        r.seq = seq_at[head];
        r.body = body_at[head];
        live[head] = 1'b0;
        if (head == tail) begin
          drained = 1'b1;
          head = 0;
          tail = 0;
        end else begin
          head = (head + 1) % DEPTH;
        end
        r.status = ST_OK;
      end
      r.now_empty = drained;
      pending_answers.push_back(r);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      if (errors <= 40) begin
        $display("mismatch on result word %0d: %s got %0h expected %0h",
                 checked, what, got, want);
      end
    endtask

    task check_response(logic [1:0] status, logic [SEQ_W-1:0] seq, logic [WORD_W-1:0] body,
                        logic now_empty);
      res_t want;
      if (pending_answers.size() == 0) begin
        report_mismatch("unexpected word, status", 32'(status), '0);
        return;
      end
      want = pending_answers.pop_front();
      checked++;
      status_count[want.status]++;
      if (status !== want.status) report_mismatch("status", 32'(status), 32'(want.status));
      if (seq !== want.seq) report_mismatch("seq_num", 32'(seq), 32'(want.seq));
      if (body !== WORD_W'(want.body)) report_mismatch("payload", 32'(body), 32'(want.body));
      if (now_empty !== want.now_empty) begin
        report_mismatch("now_empty", 32'(now_empty), 32'(want.now_empty));
      end
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_op = OP_INSERT;
  logic [SEQ_W-1:0]  in_seq_num = '0;
  logic [WORD_W-1:0] in_payload = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        out_status;
  logic [SEQ_W-1:0]  out_seq_num;
  logic [WORD_W-1:0] out_payload;
  logic              out_now_empty;

  window_mirror mirror = new();
  bit           calm = 1'b0;
  bit           hold_off = 1'b0;
  int unsigned  words_sent = 0;
  int unsigned  cycle_count = 0;

  sliding_window_packet_buffer_core i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_seq_num   (in_seq_num),
    .in_payload   (in_payload),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_seq_num  (out_seq_num),
    .out_payload  (out_payload),
    .out_now_empty(out_now_empty)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, mirror.outstanding());
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      mirror.check_response(out_status, out_seq_num, out_payload, out_now_empty);
    end
  end

  initial begin
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_off) begin
        hold_off = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  task automatic send_word(input logic op, input logic [SEQ_W-1:0] seq,
                           input logic [WORD_W-1:0] body);
    in_valid <= 1'b1;
    in_op <= op;
    in_seq_num <= seq;
    in_payload <= body;
    do @(posedge clk); while (in_stall);
    mirror.note_request(op, seq, body);
    words_sent++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  initial begin
    int unsigned      pop_pct;
    int unsigned      pick;
    logic             op;
    logic [SEQ_W-1:0] seq;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(OP_POP, '0, '0);
    send_word(OP_INSERT, '1, '1);
    send_word(OP_INSERT, '1, '0);
    send_word(OP_INSERT, '0, '0);
    send_word(OP_POP, '1, '1);
    send_word(OP_POP, '0, '0);
    send_word(OP_POP, '0, '0);
    for (int i = 0; i < DEPTH; i++) begin
      send_word(OP_INSERT, SEQ_W'(100 + i), $urandom);
    end
    send_word(OP_INSERT, SEQ_W'(100), 32'h5A5A_A5A5);
    send_word(OP_POP, '0, '0);
    send_word(OP_INSERT, SEQ_W'(101 + DEPTH), 32'hA5A5_5A5A);
    send_word(OP_INSERT, SEQ_W'(100 + DEPTH), 32'h0F0F_F0F0);

    hold_off = 1'b1;
    pop_pct = 40;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 64 == 0) pop_pct = 10 + 30 * $urandom_range(0, 2);
      if (n == RANDOM_WORDS - CALM_WORDS) calm = 1'b1;
      op = ($urandom_range(0, 99) < pop_pct) ? OP_POP : OP_INSERT;
      pick = $urandom_range(0, 99);
      if (mirror.none_held()) begin
        seq = (pick < 25) ? SEQ_W'(24'hFFFFF0 + $urandom_range(0, 15)) : SEQ_W'($urandom);
      end else if (pick < 70) begin
        seq = mirror.oldest_seq() + SEQ_W'($urandom_range(0, DEPTH - 1));
      end else if (pick < 80) begin
        seq = mirror.oldest_seq() + SEQ_W'($urandom_range(DEPTH, DEPTH + 4));
      end else if (pick < 90) begin
        seq = mirror.oldest_seq() - SEQ_W'($urandom_range(1, 8));
      end else begin
        seq = SEQ_W'($urandom);
      end
      send_word(op, seq, $urandom);
    end
    in_valid <= 1'b0;

    while (mirror.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d words: %0d ok, %0d full or out of window, %0d repeats, %0d empty pops",
             words_sent, mirror.status_count[ST_OK], mirror.status_count[ST_REFUSED],
             mirror.status_count[ST_REPEAT], mirror.status_count[ST_EMPTY]);
    $display("included a %0d-cycle receiver hold-off with the sender still offering words",
             HOLD_CYCLES);
    if (mirror.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/swpb_pkg.sv
hw/rtl/swpb_ram.sv
hw/rtl/swpb_cmp.sv
hw/rtl/swpb_ctrl.sv
hw/rtl/sliding_window_packet_buffer_core.sv
tb/sliding_window_packet_buffer_core_test.sv
